### src/conv3_pkg.sv
// Package for the 3x3 streaming convolution block.
// Configuration register codes, fixed field widths and the pipeline tag type.
// No dependencies.
`default_nettype none

package conv3_pkg;

  localparam int unsigned COEF_BITS     = 16;
  localparam int unsigned COEF_ROW_BITS = 3 * COEF_BITS;
  localparam int unsigned CONV_BITS     = 35;
  localparam int unsigned OUT_TDATA_W   = ((CONV_BITS + 7) / 8) * 8;
  localparam int unsigned WIDTH_REG_W   = 11;
  localparam int unsigned HEIGHT_REG_W  = 13;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned CFG_INDEX_W   = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_COEF_ROW0    = 3'd2,
    CFG_COEF_ROW1    = 3'd3,
    CFG_COEF_ROW2    = 3'd4
  } conv3_cfg_e;

  // request tag traveling alongside the payload through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } conv3_tag_t;

  localparam logic [COEF_ROW_BITS-1:0] COEF_ROW0_RST = 48'h0000_0000_0000;
  localparam logic [COEF_ROW_BITS-1:0] COEF_ROW1_RST = 48'h0000_2000_0000;
  localparam logic [COEF_ROW_BITS-1:0] COEF_ROW2_RST = 48'h0000_0000_0000;

endpackage

`default_nettype wire

### src/conv3_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module conv3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/conv3_mac.sv
// Multiply-accumulate pipeline for the 3x3 window: products, row sums, total.
// Uses conv3_pkg. Three register stages, the last one is the output register.
`default_nettype none

module conv3_mac #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  conv3_pkg::conv3_tag_t         in_tag_i,
  input  logic signed [SAMPLE_BITS-1:0] win_i [3][3],
  input  logic [2:0][conv3_pkg::COEF_ROW_BITS-1:0] coef_i,
  output logic                          in_ready_o,
  output conv3_pkg::conv3_tag_t         out_tag_o,
  output logic [conv3_pkg::CONV_BITS-1:0] out_value_o,
  input  logic                          out_ready_i
);
  import conv3_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_W  = (PROD_W + 4 > CONV_BITS) ? PROD_W + 4 : CONV_BITS;

  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [ACC_W-1:0]  row_sum_q [3];
  logic [CONV_BITS-1:0]     conv_q;
  conv3_tag_t               tag2_q, tag3_q, tag4_q;
  logic                     en2, en3, en4;
  logic signed [ACC_W-1:0]  row_sum_d [3];
  logic signed [ACC_W-1:0]  total_d;

  assign en4 = !tag4_q.valid || out_ready_i;
  assign en3 = !tag3_q.valid || en4;
  assign en2 = !tag2_q.valid || en3;
  assign in_ready_o = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else begin
      if (en2) tag2_q <= in_tag_i;
      if (en3) tag3_q <= tag2_q;
      if (en4) tag4_q <= tag3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= win_i[r][c] * $signed(coef_i[r][COEF_BITS*c +: COEF_BITS]);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum_d[r] = ACC_W'(prod_q[r][0]) + ACC_W'(prod_q[r][1]) + ACC_W'(prod_q[r][2]);
    end
    total_d = row_sum_q[0] + row_sum_q[1] + row_sum_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        row_sum_q[r] <= row_sum_d[r];
      end
    end
    if (en4) begin
      conv_q <= total_d[CONV_BITS-1:0];
    end
  end

  assign out_tag_o   = tag4_q;
  assign out_value_o = conv_q;

endmodule

`default_nettype wire

### src/conv3x3_valid_stream.sv
// Streaming 3x3 valid convolution (correlation, kernel not flipped).
// Uses conv3_pkg, conv3_ram (line stores) and conv3_mac (arithmetic pipeline).
//
// Samples arrive in raster order, one per request, and the block takes one
// every clock cycle when the output side keeps up. For each position with row
// and column both at least 2 it returns the exact sum of the nine window
// samples times the Q2.13 kernel (35 bits, two's complement, scaled by 2^13),
// with tlast on the last position of the frame; border positions give no
// result. From accepted sample to result valid the data passes the window
// register, product register, row-sum register and output register. The rate
// is set by the single line-store RAM, which does one read and one write per
// cycle. Both line stores share that RAM; a fill count marks the columns ever
// written, so no clearing pass is needed after reset and unwritten columns
// read as zero. Width and height are clamped to 3..MAX_WIDTH and 3..4096 and
// should be changed only while the block is idle.
`default_nettype none

module conv3x3_valid_stream #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [conv3_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [conv3_pkg::COEF_ROW_BITS-1:0]    cfg_data_i,
  // sample input
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata_i,  // sample
  // result output
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [conv3_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,  // conv_value, zero pad
  output logic                                   m_axis_tlast_o   // frame_last
);
  import conv3_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned FILL_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW     = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

  // ---------------- configuration ----------------
  logic [COL_W-1:0]                col_last_q;
  logic [ROW_W-1:0]                row_last_q;
  logic [2:0][COEF_ROW_BITS-1:0]   coef_q;
  logic [CW-1:0]                   width_ext;
  logic [CW-1:0]                   width_last;
  logic [HEIGHT_REG_W-1:0]         height_val;
  logic [HEIGHT_REG_W-1:0]         height_last;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_ext  = CW'(cfg_data_i[WIDTH_REG_W-1:0]);
    height_val = cfg_data_i[HEIGHT_REG_W-1:0];
    if (width_ext < CW'(3)) begin
      width_last = CW'(2);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_last = CW'(MAX_WIDTH - 1);
    end else begin
      width_last = width_ext - CW'(1);
    end
    if (height_val < HEIGHT_REG_W'(3)) begin
      height_last = HEIGHT_REG_W'(2);
    end else if (height_val > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      height_last = HEIGHT_REG_W'(MAX_HEIGHT - 1);
    end else begin
      height_last = height_val - HEIGHT_REG_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= COL_W'(2);
      row_last_q <= ROW_W'(2);
      coef_q[0]  <= COEF_ROW0_RST;
      coef_q[1]  <= COEF_ROW1_RST;
      coef_q[2]  <= COEF_ROW2_RST;
    end else if (cfg_valid_i) begin
      case (conv3_cfg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  col_last_q <= width_last[COL_W-1:0];
        CFG_IMAGE_HEIGHT: row_last_q <= height_last[ROW_W-1:0];
        CFG_COEF_ROW0:    coef_q[0]  <= cfg_data_i;
        CFG_COEF_ROW1:    coef_q[1]  <= cfg_data_i;
        CFG_COEF_ROW2:    coef_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- position counters and line stores ----------------
  logic [COL_W-1:0]              col_q, col_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [FILL_W-1:0]             fill_q;
  logic                          accept;
  logic                          col_end, row_end, produce, stored;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] up_s, mid_s;
  logic [2*SAMPLE_BITS-1:0]      ram_rdata;
  logic [2*SAMPLE_BITS-1:0]      ram_wdata;

  assign sample  = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign col_end = col_q >= col_last_q;
  assign row_end = row_q >= row_last_q;
  assign produce = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
  // columns at or beyond the fill count were never written and read as zero
  assign stored  = FILL_W'(col_q) < fill_q;

  // RAM word: middle row in the upper half, upper row in the lower half
  assign up_s      = stored ? ram_rdata[SAMPLE_BITS-1:0] : '0;
  assign mid_s     = stored ? ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
  assign ram_wdata = {sample, mid_s};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      fill_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept && (FILL_W'(col_q) == fill_q)) begin
        fill_q <= fill_q + FILL_W'(1);
      end
    end
  end

  // read address runs one request ahead so the data is ready with the sample
  conv3_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (ram_wdata),
    .raddr_i (col_d),
    .rdata_o (ram_rdata)
  );

  // ---------------- window register (first pipeline stage) ----------------
  logic signed [SAMPLE_BITS-1:0] win_q [3][3];
  conv3_tag_t                    tag1_q;
  logic                          mac_ready;
  logic                          en1;
  conv3_tag_t                    out_tag;
  logic [CONV_BITS-1:0]          out_value;

  assign en1             = !tag1_q.valid || mac_ready;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      if (en1) begin
        tag1_q.valid <= accept && produce;
        tag1_q.last  <= col_end && row_end;
      end
      if (accept) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= up_s;
        win_q[1][2] <= mid_s;
        win_q[2][2] <= sample;
      end
    end
  end

  conv3_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tag_i    (tag1_q),
    .win_i       (win_q),
    .coef_i      (coef_q),
    .in_ready_o  (mac_ready),
    .out_tag_o   (out_tag),
    .out_value_o (out_value),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tvalid_o = out_tag.valid;
  assign m_axis_tlast_o  = out_tag.last;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_value);

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_WIDTH))
    else $error("line store fill count beyond depth");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (tag1_q.valid && !mac_ready))
    else $error("input stalled without a held window");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && col_end && row_end) |=> (col_q == '0 && row_q == '0))
    else $error("position did not wrap at end of frame");

  a_last_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en1 && accept && produce && col_end && row_end) |=> (tag1_q.valid && tag1_q.last))
    else $error("last position lost its frame marker");

endmodule

`default_nettype wire
